/* rtl/mpc_pkg.sv */
// package: widths, types and sequencer states for the modular exponent and prime check block
`default_nettype none
package mpc_pkg;

    localparam int VALUE_BITS = 16;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIV_W      = (VALUE_BITS + 1) / 2 + 2;
    localparam int DSQ_W      = VALUE_BITS + 2;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [BIT_CNT_W-1:0]  t_bit_cnt;
    typedef logic [DIV_W-1:0]      t_div;
    typedef logic [DSQ_W-1:0]      t_dsq;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQB,
        S_BIT,
        S_MUL,
        S_SQR,
        S_PCHK,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic   start;
        t_value a;
        t_value b;
        t_value m;
    } t_mm_req;

    typedef struct packed {
        logic   done;
        t_value result;
    } t_mm_rsp;

endpackage
`default_nettype wire

/* rtl/mpc_if.sv */
// interfaces: input and output valid/ready channels of the block
`default_nettype none
interface mpc_in_if;
    logic                valid;
    logic                ready;
    mpc_pkg::t_value     base;
    mpc_pkg::t_value     exponent;
    mpc_pkg::t_value     modulus;

    modport source (output valid, output base, output exponent, output modulus, input ready);
    modport sink   (input valid, input base, input exponent, input modulus, output ready);
endinterface

interface mpc_out_if;
    logic                valid;
    logic                ready;
    mpc_pkg::t_value     residue;
    logic                is_prime;
    logic                bad_modulus;

    modport source (output valid, output residue, output is_prime, output bad_modulus, input ready);
    modport sink   (input valid, input residue, input is_prime, input bad_modulus, output ready);
endinterface
`default_nettype wire

/* rtl/mpc_mulmod.sv */
// serial modular multiplier: a*b mod m, one bit of b per cycle, msb first
`default_nettype none
module mpc_mulmod (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire mpc_pkg::t_mm_req i_req,
    output mpc_pkg::t_mm_rsp      o_rsp
);

    localparam int VB = mpc_pkg::VALUE_BITS;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    mpc_pkg::t_bit_cnt    r_cnt, n_cnt;
    mpc_pkg::t_value      r_acc, n_acc;
    mpc_pkg::t_value      r_a, n_a;
    mpc_pkg::t_value      r_b, n_b;
    mpc_pkg::t_value      r_m, n_m;

    logic [VB:0]          w_dbl;
    logic [VB:0]          w_dbl_red;
    logic [VB:0]          w_sum;
    logic [VB:0]          w_sum_red;

    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_m}) ? (w_dbl - {1'b0, r_m}) : w_dbl;
        w_sum     = w_dbl_red + (r_b[VB-1] ? {1'b0, r_a} : '0);
        w_sum_red = (w_sum >= {1'b0, r_m}) ? (w_sum - {1'b0, r_m}) : w_sum;
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = mpc_pkg::t_bit_cnt'(VB);
            n_acc  = '0;
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_m    = i_req.m;
        end else if (r_busy) begin
            n_acc = w_sum_red[VB-1:0];
            n_b   = {r_b[VB-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == mpc_pkg::t_bit_cnt'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_acc;

endmodule
`default_nettype wire

/* rtl/modexp_prime_check.sv */
// top level: square-and-multiply modular exponentiation followed by a trial-division prime test
//
// usage: one transaction on i_in (base, exponent, modulus) gives one transaction on o_out
// (residue, is_prime, bad_modulus). i_in.ready is high only while the block is idle; one
// item is worked at a time. all modular products and remainders run through one serial modular
// multiplier, so the exponent loop costs one product for the base reduction plus, per exponent
// bit, one squaring and, for a set bit, one extra multiply.
// the prime test then runs one remainder through the same multiplier per divisor d with
// d*d <= residue, up to 254 divisors at 16 bits.
// a zero modulus skips the multiplier and goes straight to the result.
// the result is held on o_out until the receiver takes it; while o_out is stalled no
// new transaction is accepted. synchronous active-low reset returns the sequencer to
// idle and drops o_out.valid; no other state needs clearing.
`default_nettype none
module modexp_prime_check (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mpc_in_if.sink    i_in,
    mpc_out_if.source o_out
);

    localparam int VB = mpc_pkg::VALUE_BITS;

    mpc_pkg::t_state   r_state, n_state;
    mpc_pkg::t_value   r_e, n_e;
    mpc_pkg::t_value   r_m, n_m;
    mpc_pkg::t_value   r_acc, n_acc;
    mpc_pkg::t_value   r_sq, n_sq;
    mpc_pkg::t_bit_cnt r_bit, n_bit;
    mpc_pkg::t_div     r_d, n_d;
    mpc_pkg::t_dsq     r_dsq, n_dsq;
    logic              r_prime, n_prime;
    logic              r_bad, n_bad;

    mpc_pkg::t_mm_req  w_req;
    mpc_pkg::t_mm_rsp  w_rsp;
    mpc_pkg::t_value   w_one_in;

    mpc_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_one_in = (i_in.modulus == mpc_pkg::t_value'(1)) ? '0 : mpc_pkg::t_value'(1);

    always_comb begin
        n_state     = r_state;
        n_e         = r_e;
        n_m         = r_m;
        n_acc       = r_acc;
        n_sq        = r_sq;
        n_bit       = r_bit;
        n_d         = r_d;
        n_dsq       = r_dsq;
        n_prime     = r_prime;
        n_bad       = r_bad;
        w_req.start = 1'b0;
        w_req.a     = r_sq;
        w_req.b     = r_sq;
        w_req.m     = r_m;
        case (r_state)
            mpc_pkg::S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.modulus == '0) begin
                        n_acc   = '0;
                        n_prime = 1'b0;
                        n_bad   = 1'b1;
                        n_state = mpc_pkg::S_DONE;
                    end else begin
                        n_e         = i_in.exponent;
                        n_m         = i_in.modulus;
                        n_acc       = w_one_in;
                        n_bad       = 1'b0;
                        w_req.start = 1'b1;
                        w_req.a     = w_one_in;
                        w_req.b     = i_in.base;
                        w_req.m     = i_in.modulus;
                        n_state     = mpc_pkg::S_SQB;
                    end
                end
            end
            mpc_pkg::S_SQB: begin
                if (w_rsp.done) begin
                    n_sq    = w_rsp.result;
                    n_bit   = '0;
                    n_state = mpc_pkg::S_BIT;
                end
            end
            mpc_pkg::S_BIT: begin
                if (r_bit == mpc_pkg::t_bit_cnt'(VB)) begin
                    n_d     = mpc_pkg::t_div'(2);
                    n_dsq   = mpc_pkg::t_dsq'(4);
                    n_state = mpc_pkg::S_PCHK;
                end else if (r_e[0]) begin
                    w_req.start = 1'b1;
                    w_req.a     = r_acc;
                    n_state     = mpc_pkg::S_MUL;
                end else begin
                    w_req.start = 1'b1;
                    n_state     = mpc_pkg::S_SQR;
                end
            end
            mpc_pkg::S_MUL: begin
                if (w_rsp.done) begin
                    n_acc       = w_rsp.result;
                    w_req.start = 1'b1;
                    n_state     = mpc_pkg::S_SQR;
                end
            end
            mpc_pkg::S_SQR: begin
                if (w_rsp.done) begin
                    n_sq    = w_rsp.result;
                    n_e     = {1'b0, r_e[VB-1:1]};
                    n_bit   = r_bit + 1'b1;
                    n_state = mpc_pkg::S_BIT;
                end
            end
            mpc_pkg::S_PCHK: begin
                if (r_acc < mpc_pkg::t_value'(2)) begin
                    n_prime = 1'b0;
                    n_state = mpc_pkg::S_DONE;
                end else if (r_dsq > mpc_pkg::t_dsq'(r_acc)) begin
                    n_prime = 1'b1;
                    n_state = mpc_pkg::S_DONE;
                end else begin
                    w_req.start = 1'b1;
                    w_req.a     = mpc_pkg::t_value'(1);
                    w_req.b     = r_acc;
                    w_req.m     = mpc_pkg::t_value'(r_d);
                    n_state     = mpc_pkg::S_DIV;
                end
            end
            mpc_pkg::S_DIV: begin
                if (w_rsp.done) begin
                    if (w_rsp.result == '0) begin
                        n_prime = 1'b0;
                        n_state = mpc_pkg::S_DONE;
                    end else begin
                        n_d     = r_d + 1'b1;
                        n_dsq   = r_dsq + mpc_pkg::t_dsq'({r_d, 1'b0}) + 1'b1;
                        n_state = mpc_pkg::S_PCHK;
                    end
                end
            end
            mpc_pkg::S_DONE: begin
                if (o_out.ready) begin
                    n_state = mpc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mpc_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_e     <= n_e;
        r_m     <= n_m;
        r_acc   <= n_acc;
        r_sq    <= n_sq;
        r_bit   <= n_bit;
        r_d     <= n_d;
        r_dsq   <= n_dsq;
        r_prime <= n_prime;
        r_bad   <= n_bad;
    end

    assign i_in.ready        = i_rst_n && (r_state == mpc_pkg::S_IDLE);
    assign o_out.valid       = i_rst_n && (r_state == mpc_pkg::S_DONE);
    assign o_out.residue     = r_acc;
    assign o_out.is_prime    = r_prime;
    assign o_out.bad_modulus = r_bad;

endmodule
`default_nettype wire

/* sim/tb_top.sv */
// testbench for modexp_prime_check: random and corner-case transactions checked against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 30000;
    localparam int HOLD_CYCLES = 400;
    localparam int N_RANDOM    = 100;

    class residue_scoreboard;
        typedef struct {
            mpc_pkg::t_value base;
            mpc_pkg::t_value exponent;
            mpc_pkg::t_value modulus;
            mpc_pkg::t_value residue;
            logic            is_prime;
            logic            bad_modulus;
        } t_expect;

        t_expect expected_q[$];
        int      n_fail;

        function new();
            n_fail = 0;
        endfunction

        function mpc_pkg::t_value power_mod(mpc_pkg::t_value b, mpc_pkg::t_value e,
                                            mpc_pkg::t_value m);
            logic [63:0] acc;
            logic [63:0] sq;
            int          k;
            acc = 64'd1 % m;
            sq  = b % m;
            for (k = 0; k < mpc_pkg::VALUE_BITS; k++) begin
                if (e[k]) begin
                    acc = (acc * sq) % m;
                end
                sq = (sq * sq) % m;
            end
            return acc[mpc_pkg::VALUE_BITS-1:0];
        endfunction

        function logic prime_value(mpc_pkg::t_value r);
            logic [31:0] d;
            if (r < 2) begin
                return 1'b0;
            end
            for (d = 2; d * d <= r; d++) begin
                if (r % d == 0) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_input(mpc_pkg::t_value b, mpc_pkg::t_value e, mpc_pkg::t_value m);
            t_expect x;
            x.base     = b;
            x.exponent = e;
            x.modulus  = m;
            if (m == 0) begin
                x.residue     = '0;
                x.is_prime    = 1'b0;
                x.bad_modulus = 1'b1;
            end else begin
                x.residue     = power_mod(b, e, m);
                x.is_prime    = prime_value(x.residue);
                x.bad_modulus = 1'b0;
            end
            expected_q.push_back(x);
        endfunction

        task report(string what);
            $display("%0t mismatch: %s", $realtime, what);
            n_fail++;
        endtask

        task check_result(mpc_pkg::t_value r, logic p, logic bad);
            t_expect x;
            string   ctx;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected transaction residue=%0d is_prime=%0b bad=%0b",
                                 r, p, bad));
                return;
            end
            x   = expected_q.pop_front();
            ctx = $sformatf("(base=%0d exponent=%0d modulus=%0d)",
                            x.base, x.exponent, x.modulus);
            if (r !== x.residue) begin
                report($sformatf("residue got %0d want %0d %s", r, x.residue, ctx));
            end
            if (p !== x.is_prime) begin
                report($sformatf("is_prime got %0b want %0b %s", p, x.is_prime, ctx));
            end
            if (bad !== x.bad_modulus) begin
                report($sformatf("bad_modulus got %0b want %0b %s", bad, x.bad_modulus, ctx));
            end
        endtask

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   steady;
    bit   hold_req;
    int   idle_cycles;

    mpc_in_if  in_ch();
    mpc_out_if out_ch();

    residue_scoreboard sb = new();

    modexp_prime_check dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 95) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(30, 120);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            sb.note_input(in_ch.base, in_ch.exponent, in_ch.modulus);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            sb.check_result(out_ch.residue, out_ch.is_prime, out_ch.bad_modulus);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side
    initial begin
        int stall;
        stall        = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (steady) begin
                out_ch.ready = 1'b1;
            end else if (stall > 0) begin
                out_ch.ready = 1'b0;
                stall--;
            end else if ($urandom_range(0, 9) < 3) begin
                out_ch.ready = 1'b0;
                stall        = idle_gap();
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    task send_item(mpc_pkg::t_value b, mpc_pkg::t_value e, mpc_pkg::t_value m);
        int gap;
        gap = steady ? 0 : idle_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.base     = b;
        in_ch.exponent = e;
        in_ch.modulus  = m;
        in_ch.valid    = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task drain();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        int              i;
        int              r;
        mpc_pkg::t_value b;
        mpc_pkg::t_value e;
        mpc_pkg::t_value m;
        steady         = 1'b0;
        hold_req       = 1'b0;
        idle_cycles    = 0;
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.base     = '0;
        in_ch.exponent = '0;
        in_ch.modulus  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero modulus
        send_item(16'd0, 16'd0, 16'd0);
        send_item(16'hFFFF, 16'hFFFF, 16'd0);
        // zero exponent and zero base
        send_item(16'd5, 16'd0, 16'd1);
        send_item(16'd5, 16'd0, 16'd7);
        send_item(16'd0, 16'd0, 16'hFFFF);
        send_item(16'd0, 16'd5, 16'd13);
        // field extremes
        send_item(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(16'd7, 16'hFFFF, 16'd1);
        send_item(16'hFFFF, 16'd1, 16'd2);
        send_item(16'd1, 16'hFFFF, 16'hFFFE);
        // prime and composite residues, mostly with moduli near the top of the range
        send_item(16'd2, 16'd1, 16'hFFFF);
        send_item(16'd65521, 16'd1, 16'hFFFF);
        send_item(16'd65534, 16'd1, 16'hFFFF);
        send_item(16'd3, 16'hFFFF, 16'd65521);
        send_item(16'd2, 16'h8000, 16'd65521);
        send_item(16'd3, 16'd2, 16'd11);
        send_item(16'd2, 16'd10, 16'hFFFF);
        send_item(16'd4, 16'd1, 16'hFFFF);
        send_item(16'd12345, 16'd54321, 16'hFFFF);

        for (i = 0; i < N_RANDOM; i++) begin
            steady = (i >= 70 && i < 90);
            if (i == 30) begin
                hold_req = 1'b1;
            end
            if (i == 55) begin
                drain();
            end
            r = $urandom_range(0, 99);
            if (r < 4) begin
                m = '0;
            end else if (r < 25) begin
                m = mpc_pkg::t_value'($urandom_range(1, 40));
            end else begin
                m = mpc_pkg::t_value'($urandom_range(1, 65535));
            end
            b = ($urandom_range(0, 9) < 7) ? mpc_pkg::t_value'($urandom)
                                           : mpc_pkg::t_value'($urandom_range(0, 20));
            e = ($urandom_range(0, 9) < 8) ? mpc_pkg::t_value'($urandom)
                                           : mpc_pkg::t_value'($urandom_range(0, 5));
            send_item(b, e, m);
        end
        steady = 1'b0;

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.n_fail == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end
endmodule

/* modexp_prime_check.f */
rtl/mpc_pkg.sv
rtl/mpc_if.sv
rtl/mpc_mulmod.sv
rtl/modexp_prime_check.sv
sim/tb_top.sv
